// ===== design/usbspi_pkg.sv =====
`default_nettype none

package usbspi_pkg;

    localparam int BUFFER_BYTES_DEF = 512;

    localparam int OPCODE_W = 3;
    localparam int OLEN_W   = 9;
    localparam int COUNT_W  = 24;
    localparam int LEN_W    = 10;
    localparam int ACTION_W = 3;
    localparam int SRC_W    = 2;
    localparam int BYTE_W   = 8;

    localparam logic [OLEN_W-1:0] HDR_BYTES = 9'd4;

    // Event codes.
    localparam logic [OPCODE_W-1:0] EV_ENABLE   = 3'd0;
    localparam logic [OPCODE_W-1:0] EV_DISABLE  = 3'd1;
    localparam logic [OPCODE_W-1:0] EV_OUT_DONE = 3'd2;
    localparam logic [OPCODE_W-1:0] EV_SPI_DONE = 3'd3;
    localparam logic [OPCODE_W-1:0] EV_IN_DONE  = 3'd4;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_NONE  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SPI   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_IN    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ARM   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ABORT = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_FAULT = 3'd5;

    // Transmit source and receive destination codes.
    localparam logic [SRC_W-1:0] TX_DUMMY   = 2'd0;
    localparam logic [SRC_W-1:0] TX_CMD     = 2'd1;
    localparam logic [SRC_W-1:0] TX_PAYLOAD = 2'd2;
    localparam logic [SRC_W-1:0] RX_DISCARD = 2'd0;
    localparam logic [SRC_W-1:0] RX_STATUS  = 2'd1;
    localparam logic [SRC_W-1:0] RX_BUFFER  = 2'd2;

    // Flash commands.
    localparam logic [BYTE_W-1:0] CMD_NONE   = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_READSR = 8'h05;
    localparam logic [BYTE_W-1:0] CMD_WREN   = 8'h06;

endpackage

`default_nettype wire

// ===== design/usb_spi_flash_bridge_sequencer_top.sv =====
`default_nettype none

// Event sequencer for a host-packet to SPI-flash bridge. Each request on the
// slave stream is one event (enable, disable, host OUT done, SPI done, host IN
// done) and yields exactly one result on the master stream that tells the
// surrounding engines what to do next: start an SPI transfer, send an IN chunk,
// rearm OUT, abort, report a fault, or do nothing. One event is taken every clock
// cycle while the result stream is not stalled; each event passes an input
// register and then a result register. o_s_axis_tready follows i_m_axis_tready
// combinationally when both registers are full. Reads are split into chunks of
// at most BUFFER_BYTES; transfer_length carries the low 10 bits of the count.
module usb_spi_flash_bridge_sequencer_top #(
    parameter int BUFFER_BYTES = usbspi_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [8:0] out_length, [32:9] read_count, [33] flag_status_poll,
    // [34] flag_write_enable, [42:35] status_byte, [47:43] zero
    input  wire logic [47:0] i_s_axis_tdata,
    // [2:0] opcode
    input  wire logic [2:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [0] cs_release_first, [1] cs_active, [3:2] tx_source, [11:4] command_byte,
    // [13:12] rx_keep, [23:14] transfer_length
    output logic [23:0]      o_m_axis_tdata,
    // [2:0] action
    output logic [2:0]       o_m_axis_tuser
);

    localparam logic [usbspi_pkg::COUNT_W-1:0] BUF_LEN =
        usbspi_pkg::COUNT_W'(BUFFER_BYTES);

    typedef enum logic [2:0] {
        PH_DISABLED  = 3'd0,
        PH_IDLE      = 3'd1,
        PH_OUT       = 3'd2,
        PH_IN_SPI    = 3'd3,
        PH_IN_USB    = 3'd4,
        PH_POLL_CMD  = 3'd5,
        PH_POLL_READ = 3'd6,
        PH_WREN      = 3'd7
    } t_phase;

    // Sequencer state.
    t_phase                            r_phase, n_phase;
    logic [usbspi_pkg::COUNT_W-1:0]    r_bytes, n_bytes;
    logic [usbspi_pkg::OLEN_W-1:0]     r_payload, n_payload;
    logic                              r_poll, n_poll;
    logic                              r_wren, n_wren;

    // Input register.
    logic                              r_in_valid;
    logic [usbspi_pkg::OPCODE_W-1:0]   r_in_op;
    logic [usbspi_pkg::OLEN_W-1:0]     r_in_olen;
    logic [usbspi_pkg::COUNT_W-1:0]    r_in_count;
    logic                              r_in_fpoll;
    logic                              r_in_fwren;
    logic                              r_in_status0;

    // Result register.
    logic                              r_out_valid;
    logic [usbspi_pkg::ACTION_W-1:0]   r_out_action, n_action;
    logic                              r_out_release, n_release;
    logic                              r_out_cs, n_cs;
    logic [usbspi_pkg::SRC_W-1:0]      r_out_tx, n_tx;
    logic [usbspi_pkg::BYTE_W-1:0]     r_out_cmd, n_cmd;
    logic [usbspi_pkg::SRC_W-1:0]      r_out_rx, n_rx;
    logic [usbspi_pkg::LEN_W-1:0]      r_out_len, n_len;

    logic                              advance;
    logic [usbspi_pkg::COUNT_W-1:0]    cur_chunk;
    logic                              ch_poll, ch_wren, ch_write, ch_read, ch_on;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    assign cur_chunk = (r_bytes > BUF_LEN) ? BUF_LEN : r_bytes;

    always_comb begin
        n_phase   = r_phase;
        n_bytes   = r_bytes;
        n_payload = r_payload;
        n_poll    = r_poll;
        n_wren    = r_wren;
        n_action  = usbspi_pkg::ACT_NONE;
        n_release = 1'b0;
        n_tx      = usbspi_pkg::TX_DUMMY;
        n_cmd     = usbspi_pkg::CMD_NONE;
        n_rx      = usbspi_pkg::RX_DISCARD;
        n_len     = '0;
        ch_poll   = 1'b0;
        ch_wren   = 1'b0;
        ch_write  = 1'b0;
        ch_read   = 1'b0;
        ch_on     = 1'b0;

        unique case (r_in_op)
            usbspi_pkg::EV_ENABLE: begin
                n_action  = usbspi_pkg::ACT_ARM;
                n_release = (r_phase != PH_DISABLED) && (r_phase != PH_IDLE);
                n_phase   = PH_IDLE;
            end
            usbspi_pkg::EV_DISABLE: begin
                n_action  = usbspi_pkg::ACT_ABORT;
                n_release = (r_phase != PH_DISABLED) && (r_phase != PH_IDLE);
                n_phase   = PH_DISABLED;
            end
            usbspi_pkg::EV_OUT_DONE: begin
                if (r_phase != PH_IDLE) begin
                    n_action = usbspi_pkg::ACT_FAULT;
                end else if (r_in_olen >= usbspi_pkg::HDR_BYTES) begin
                    n_payload = r_in_olen - usbspi_pkg::HDR_BYTES;
                    n_bytes   = r_in_count;
                    n_poll    = r_in_fpoll;
                    n_wren    = r_in_fwren;
                    ch_poll   = 1'b1;
                end
            end
            usbspi_pkg::EV_SPI_DONE: begin
                unique case (r_phase)
                    PH_DISABLED: begin
                    end
                    PH_POLL_CMD, PH_POLL_READ: begin
                        if (r_phase == PH_POLL_READ && !r_in_status0) begin
                            n_release = 1'b1;
                            ch_wren   = 1'b1;
                        end else begin
                            n_action = usbspi_pkg::ACT_SPI;
                            n_rx     = usbspi_pkg::RX_STATUS;
                            n_len    = usbspi_pkg::LEN_W'(1);
                            n_phase  = PH_POLL_READ;
                        end
                    end
                    PH_WREN: begin
                        n_release = 1'b1;
                        ch_write  = 1'b1;
                    end
                    PH_OUT: begin
                        ch_read = 1'b1;
                        ch_on   = 1'b1;
                    end
                    PH_IN_SPI: begin
                        n_action = usbspi_pkg::ACT_IN;
                        n_len    = cur_chunk[usbspi_pkg::LEN_W-1:0];
                        n_phase  = PH_IN_USB;
                    end
                    default: begin
                        n_action = usbspi_pkg::ACT_FAULT;
                    end
                endcase
            end
            usbspi_pkg::EV_IN_DONE: begin
                if (r_phase == PH_IN_USB) begin
                    n_bytes = r_bytes - cur_chunk;
                    ch_read = 1'b1;
                    ch_on   = 1'b1;
                end else begin
                    n_action = usbspi_pkg::ACT_FAULT;
                end
            end
            default: begin
                n_action = usbspi_pkg::ACT_FAULT;
            end
        endcase

        // Walk the start chain: poll, write enable, payload, read, finish.
        if (ch_poll) begin
            if (n_poll) begin
                n_action = usbspi_pkg::ACT_SPI;
                n_tx     = usbspi_pkg::TX_CMD;
                n_cmd    = usbspi_pkg::CMD_READSR;
                n_len    = usbspi_pkg::LEN_W'(1);
                n_phase  = PH_POLL_CMD;
            end else begin
                ch_wren = 1'b1;
            end
        end
        if (ch_wren) begin
            if (n_wren) begin
                n_action = usbspi_pkg::ACT_SPI;
                n_tx     = usbspi_pkg::TX_CMD;
                n_cmd    = usbspi_pkg::CMD_WREN;
                n_len    = usbspi_pkg::LEN_W'(1);
                n_phase  = PH_WREN;
            end else begin
                ch_write = 1'b1;
            end
        end
        if (ch_write) begin
            if (n_payload != '0) begin
                n_action = usbspi_pkg::ACT_SPI;
                n_tx     = usbspi_pkg::TX_PAYLOAD;
                n_len    = usbspi_pkg::LEN_W'(n_payload);
                n_phase  = PH_OUT;
            end else begin
                ch_read = 1'b1;
            end
        end
        if (ch_read) begin
            if (n_bytes != '0) begin
                n_action = usbspi_pkg::ACT_SPI;
                n_rx     = usbspi_pkg::RX_BUFFER;
                n_len    = (n_bytes > BUF_LEN) ? BUF_LEN[usbspi_pkg::LEN_W-1:0]
                                               : n_bytes[usbspi_pkg::LEN_W-1:0];
                n_phase  = PH_IN_SPI;
            end else begin
                // Finishing overrides any earlier release with the chain's view.
                n_action  = usbspi_pkg::ACT_ARM;
                n_release = ch_on;
                n_phase   = PH_IDLE;
            end
        end

        n_cs = (n_phase != PH_DISABLED) && (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DISABLED;
            r_bytes     <= '0;
            r_payload   <= '0;
            r_poll      <= 1'b0;
            r_wren      <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid   <= i_s_axis_tvalid;
                r_in_op      <= i_s_axis_tuser;
                r_in_olen    <= i_s_axis_tdata[8:0];
                r_in_count   <= i_s_axis_tdata[32:9];
                r_in_fpoll   <= i_s_axis_tdata[33];
                r_in_fwren   <= i_s_axis_tdata[34];
                r_in_status0 <= i_s_axis_tdata[35];
            end
            if (advance) begin
                r_phase       <= n_phase;
                r_bytes       <= n_bytes;
                r_payload     <= n_payload;
                r_poll        <= n_poll;
                r_wren        <= n_wren;
                r_out_valid   <= 1'b1;
                r_out_action  <= n_action;
                r_out_release <= n_release;
                r_out_cs      <= n_cs;
                r_out_tx      <= n_tx;
                r_out_cmd     <= n_cmd;
                r_out_rx      <= n_rx;
                r_out_len     <= n_len;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_action;
    assign o_m_axis_tdata  = {r_out_len, r_out_rx, r_out_cmd, r_out_tx,
                              r_out_cs, r_out_release};

    // The reported chip-select level matches the phase the event left behind.
    a_cs_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_cs == ((r_phase != PH_DISABLED) && (r_phase != PH_IDLE))))
        else $error("cs_active disagrees with the sequencer phase");

    // A faulting event leaves the phase untouched.
    a_fault_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (n_action == usbspi_pkg::ACT_FAULT)) |=> (r_phase == $past(r_phase)))
        else $error("fault result changed the phase");

    // A command byte is only reported together with a command transmit source.
    a_cmd_with_tx_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_cmd != usbspi_pkg::CMD_NONE))
            |-> (r_out_tx == usbspi_pkg::TX_CMD))
        else $error("command byte without command transmit source");

    // A waiting result is never dropped: holding it blocks the next event.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready && r_in_valid) |-> !advance)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== dv/usb_spi_flash_bridge_sequencer_top_test.sv =====
`timescale 1ns / 100ps

module usb_spi_flash_bridge_sequencer_top_test;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int BUF_BYTES     = usbspi_pkg::BUFFER_BYTES_DEF;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int MAX_TXN_STEPS = 20;

    localparam int OPCODE_W = usbspi_pkg::OPCODE_W;
    localparam int OLEN_W   = usbspi_pkg::OLEN_W;
    localparam int COUNT_W  = usbspi_pkg::COUNT_W;
    localparam int LEN_W    = usbspi_pkg::LEN_W;
    localparam int ACTION_W = usbspi_pkg::ACTION_W;
    localparam int SRC_W    = usbspi_pkg::SRC_W;
    localparam int BYTE_W   = usbspi_pkg::BYTE_W;

    // Event codes the block does not define; each one must give a fault.
    localparam logic [OPCODE_W-1:0] EV_BAD_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0] EV_BAD_LAST  = 3'd7;

    typedef enum logic [2:0] {
        S_DISABLED,
        S_IDLE,
        S_PAYLOAD,
        S_READ_SPI,
        S_READ_HOST,
        S_POLL_CMD,
        S_POLL_STATUS,
        S_WREN
    } seq_phase_e;

    // Where in the poll, write-enable, payload, read chain the next step starts.
    typedef enum int {
        START_POLL,
        START_WREN,
        START_PAYLOAD,
        START_READ
    } chain_start_e;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [OLEN_W-1:0]   out_length;
        logic [COUNT_W-1:0]  read_count;
        logic                poll;
        logic                wren;
        logic [BYTE_W-1:0]   status;
    } flash_event_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                cs_release_first;
        logic                cs_active;
        logic [SRC_W-1:0]    tx_source;
        logic [BYTE_W-1:0]   command_byte;
        logic [SRC_W-1:0]    rx_keep;
        logic [LEN_W-1:0]    transfer_length;
    } bridge_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [8:0] out_length, [32:9] read_count, [33] flag_status_poll,
    // [34] flag_write_enable, [42:35] status_byte, [47:43] zero
    logic [47:0] i_s_axis_tdata = '0;
    // [2:0] opcode
    logic [2:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [0] cs_release_first, [1] cs_active, [3:2] tx_source, [11:4] command_byte,
    // [13:12] rx_keep, [23:14] transfer_length
    logic [23:0] o_m_axis_tdata;
    // [2:0] action
    logic [2:0]  o_m_axis_tuser;

    // Predicted sequencer state.
    seq_phase_e         flash_phase = S_DISABLED;
    logic [COUNT_W-1:0] bytes_left = '0;
    logic [OLEN_W-1:0]  payload_len = '0;
    logic               poll_armed = 1'b0;
    logic               wren_armed = 1'b0;

    bridge_result_t expected_results[$];

    bit sender_gaps = 1'b1;
    bit receiver_gaps = 1'b1;
    int cycle_count = 0;
    int events_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int transactions = 0;
    int status_polls = 0;

    usb_spi_flash_bridge_sequencer_top #(
        .BUFFER_BYTES(BUF_BYTES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= !receiver_gaps || ($urandom_range(99) >= 11);
    end

    function automatic logic [COUNT_W-1:0] next_chunk();
        return (bytes_left > BUF_BYTES) ? COUNT_W'(BUF_BYTES) : bytes_left;
    endfunction

    function automatic void start_spi(inout bridge_result_t r, input logic [SRC_W-1:0] tx,
                                      input logic [BYTE_W-1:0] cmd,
                                      input logic [SRC_W-1:0] rx,
                                      input logic [COUNT_W-1:0] len,
                                      input seq_phase_e next_phase);
        r.action          = usbspi_pkg::ACT_SPI;
        r.tx_source       = tx;
        r.command_byte    = cmd;
        r.rx_keep         = rx;
        r.transfer_length = len[LEN_W-1:0];
        flash_phase       = next_phase;
    endfunction

    // Runs the remaining steps of the chain; when nothing is left, OUT is rearmed and
    // the release flag is set from was_on alone, overriding any earlier setting.
    function automatic void advance_chain(inout bridge_result_t r, input chain_start_e start_at,
                                          input logic was_on);
        if (start_at == START_POLL && poll_armed) begin
            start_spi(r, usbspi_pkg::TX_CMD, usbspi_pkg::CMD_READSR, usbspi_pkg::RX_DISCARD,
                      COUNT_W'(1), S_POLL_CMD);
        end else if (start_at <= START_WREN && wren_armed) begin
            start_spi(r, usbspi_pkg::TX_CMD, usbspi_pkg::CMD_WREN, usbspi_pkg::RX_DISCARD,
                      COUNT_W'(1), S_WREN);
        end else if (start_at <= START_PAYLOAD && payload_len != '0) begin
            start_spi(r, usbspi_pkg::TX_PAYLOAD, usbspi_pkg::CMD_NONE, usbspi_pkg::RX_DISCARD,
                      COUNT_W'(payload_len), S_PAYLOAD);
        end else if (bytes_left != '0) begin
            start_spi(r, usbspi_pkg::TX_DUMMY, usbspi_pkg::CMD_NONE, usbspi_pkg::RX_BUFFER,
                      next_chunk(), S_READ_SPI);
        end else begin
            r.action           = usbspi_pkg::ACT_ARM;
            r.cs_release_first = was_on;
            flash_phase        = S_IDLE;
        end
    endfunction

    function automatic bridge_result_t predict_event(input flash_event_t ev);
        bridge_result_t     r;
        logic               was_on;
        logic [COUNT_W-1:0] chunk;
        r      = '0;
        was_on = (flash_phase != S_DISABLED) && (flash_phase != S_IDLE);
        case (ev.opcode)
            usbspi_pkg::EV_ENABLE: begin
                r.action           = usbspi_pkg::ACT_ARM;
                r.cs_release_first = was_on;
                flash_phase        = S_IDLE;
            end
            usbspi_pkg::EV_DISABLE: begin
                r.action           = usbspi_pkg::ACT_ABORT;
                r.cs_release_first = was_on;
                flash_phase        = S_DISABLED;
            end
            usbspi_pkg::EV_OUT_DONE: begin
                if (flash_phase != S_IDLE) begin
                    r.action = usbspi_pkg::ACT_FAULT;
                end else if (ev.out_length >= usbspi_pkg::HDR_BYTES) begin
                    payload_len = ev.out_length - usbspi_pkg::HDR_BYTES;
                    bytes_left  = ev.read_count;
                    poll_armed  = ev.poll;
                    wren_armed  = ev.wren;
                    advance_chain(r, START_POLL, 1'b0);
                end
            end
            usbspi_pkg::EV_SPI_DONE: begin
                case (flash_phase)
                    S_DISABLED: begin
                    end
                    S_POLL_CMD: begin
                        start_spi(r, usbspi_pkg::TX_DUMMY, usbspi_pkg::CMD_NONE,
                                  usbspi_pkg::RX_STATUS, COUNT_W'(1), S_POLL_STATUS);
                    end
                    S_POLL_STATUS: begin
                        if (!ev.status[0]) begin
                            r.cs_release_first = 1'b1;
                            advance_chain(r, START_WREN, 1'b0);
                        end else begin
                            start_spi(r, usbspi_pkg::TX_DUMMY, usbspi_pkg::CMD_NONE,
                                      usbspi_pkg::RX_STATUS, COUNT_W'(1), S_POLL_STATUS);
                        end
                    end
                    S_WREN: begin
                        r.cs_release_first = 1'b1;
                        advance_chain(r, START_PAYLOAD, 1'b0);
                    end
                    S_PAYLOAD: begin
                        advance_chain(r, START_READ, 1'b1);
                    end
                    S_READ_SPI: begin
                        chunk             = next_chunk();
                        r.action          = usbspi_pkg::ACT_IN;
                        r.transfer_length = chunk[LEN_W-1:0];
                        flash_phase       = S_READ_HOST;
                    end
                    default: begin
                        r.action = usbspi_pkg::ACT_FAULT;
                    end
                endcase
            end
            usbspi_pkg::EV_IN_DONE: begin
                if (flash_phase == S_READ_HOST) begin
                    bytes_left = bytes_left - next_chunk();
                    advance_chain(r, START_READ, 1'b1);
                end else begin
                    r.action = usbspi_pkg::ACT_FAULT;
                end
            end
            default: begin
                r.action = usbspi_pkg::ACT_FAULT;
            end
        endcase
        r.cs_active = (flash_phase != S_DISABLED) && (flash_phase != S_IDLE);
        return r;
    endfunction

    function automatic string describe(input bridge_result_t r);
        return $sformatf("action=%0d release=%0b cs=%0b tx=%0d cmd=%02h rx=%0d len=%0d",
                         r.action, r.cs_release_first, r.cs_active, r.tx_source,
                         r.command_byte, r.rx_keep, r.transfer_length);
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] %s", $time, msg);
        end
    endfunction

    // Outputs are sampled at the falling edge, where they are stable; a result is
    // taken at the next rising edge when valid and ready were both high here.
    always @(negedge i_clk) begin : result_check
        bridge_result_t got;
        bridge_result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.action           = o_m_axis_tuser;
            got.cs_release_first = o_m_axis_tdata[0];
            got.cs_active        = o_m_axis_tdata[1];
            got.tx_source        = o_m_axis_tdata[3:2];
            got.command_byte     = o_m_axis_tdata[11:4];
            got.rx_keep          = o_m_axis_tdata[13:12];
            got.transfer_length  = o_m_axis_tdata[23:14];
            if (expected_results.size() == 0) begin
                note_mismatch({"result with no pending request: ", describe(got)});
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (got !== want) begin
                    note_mismatch({"mismatch\n  expected ", describe(want),
                                   "\n  actual   ", describe(got)});
                end
            end
        end
    end

    // Called at a rising edge; returns at the rising edge where the request was taken.
    task automatic issue_event(input flash_event_t ev);
        logic taken;
        while (sender_gaps && $urandom_range(99) < 11) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, ev.status, ev.wren, ev.poll, ev.read_count, ev.out_length};
        i_s_axis_tuser  <= ev.opcode;
        do begin
            @(negedge i_clk);
            taken = o_s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        expected_results.push_back(predict_event(ev));
        events_sent++;
    endtask

    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // An event with the given code and random contents in the fields it does not use.
    function automatic flash_event_t event_of(input logic [OPCODE_W-1:0] op);
        flash_event_t ev;
        ev.opcode     = op;
        ev.out_length = OLEN_W'($urandom());
        ev.read_count = COUNT_W'($urandom());
        ev.poll       = 1'($urandom());
        ev.wren       = 1'($urandom());
        ev.status     = BYTE_W'($urandom());
        return ev;
    endfunction

    function automatic flash_event_t out_packet(input logic [OLEN_W-1:0] olen,
                                                input logic [COUNT_W-1:0] count,
                                                input logic poll, input logic wren);
        flash_event_t ev;
        ev            = event_of(usbspi_pkg::EV_OUT_DONE);
        ev.out_length = olen;
        ev.read_count = count;
        ev.poll       = poll;
        ev.wren       = wren;
        return ev;
    endfunction

    function automatic flash_event_t status_done(input logic [BYTE_W-1:0] status);
        flash_event_t ev;
        ev        = event_of(usbspi_pkg::EV_SPI_DONE);
        ev.status = status;
        return ev;
    endfunction

    task automatic test_disabled_events();
        issue_event(event_of(usbspi_pkg::EV_SPI_DONE));
        issue_event(event_of(usbspi_pkg::EV_IN_DONE));
        issue_event(out_packet(9'd511, 24'd16, 1'b0, 1'b0));
        issue_event(event_of(EV_BAD_FIRST));
        issue_event(event_of(EV_BAD_LAST));
        issue_event(event_of(usbspi_pkg::EV_DISABLE));
    endtask

    task automatic test_idle_events();
        issue_event(event_of(usbspi_pkg::EV_ENABLE));
        issue_event(out_packet(9'd3, 24'hFFFFFF, 1'b1, 1'b1));
        issue_event(out_packet(9'd0, 24'd100, 1'b0, 1'b1));
        issue_event(event_of(usbspi_pkg::EV_SPI_DONE));
        issue_event(event_of(usbspi_pkg::EV_IN_DONE));
        // Nothing to send or read: OUT is rearmed at once.
        issue_event(out_packet(9'd4, 24'd0, 1'b0, 1'b0));
    endtask

    task automatic test_flash_read_sequence();
        issue_event(out_packet(9'd14, 24'd513, 1'b1, 1'b1));
        issue_event(event_of(usbspi_pkg::EV_SPI_DONE));
        issue_event(status_done(8'hFF));
        issue_event(out_packet(9'd20, 24'd1, 1'b0, 1'b0));
        issue_event(status_done(8'hFE));
        issue_event(event_of(usbspi_pkg::EV_SPI_DONE));
        issue_event(event_of(usbspi_pkg::EV_IN_DONE));
        issue_event(event_of(usbspi_pkg::EV_SPI_DONE));
        issue_event(event_of(usbspi_pkg::EV_SPI_DONE));
        issue_event(event_of(usbspi_pkg::EV_IN_DONE));
        issue_event(event_of(usbspi_pkg::EV_SPI_DONE));
        issue_event(event_of(usbspi_pkg::EV_IN_DONE));
    endtask

    task automatic test_mid_flight_restart();
        issue_event(out_packet(9'd511, 24'hFFFFFF, 1'b0, 1'b0));
        issue_event(event_of(usbspi_pkg::EV_SPI_DONE));
        issue_event(event_of(usbspi_pkg::EV_ENABLE));
        issue_event(out_packet(9'd4, 24'hFFFFFF, 1'b0, 1'b0));
        issue_event(event_of(usbspi_pkg::EV_DISABLE));
    endtask

    function automatic logic [COUNT_W-1:0] random_count();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return COUNT_W'($urandom());
        end else if (pick <= 4) begin
            return COUNT_W'(BUF_BYTES - 1 + $urandom_range(2) + BUF_BYTES * $urandom_range(1));
        end
        return COUNT_W'($urandom_range(1, 1500));
    endfunction

    // One host packet followed through its chain with the events the engines would
    // report, with occasional stray events, and a restart or abort if it runs long.
    task automatic run_transaction();
        flash_event_t ev;
        int           steps;
        if (flash_phase != S_IDLE) begin
            issue_event(event_of(usbspi_pkg::EV_ENABLE));
        end
        ev = out_packet(($urandom_range(9) == 0) ? OLEN_W'($urandom())
                                                 : OLEN_W'($urandom_range(4, 24)),
                        random_count(), 1'($urandom()), 1'($urandom()));
        issue_event(ev);
        transactions++;
        steps = 1;
        while (flash_phase != S_IDLE && flash_phase != S_DISABLED && steps < MAX_TXN_STEPS) begin
            if ($urandom_range(99) < 6) begin
                ev = event_of(OPCODE_W'($urandom()));
            end else if (flash_phase == S_READ_HOST) begin
                ev = event_of(usbspi_pkg::EV_IN_DONE);
            end else begin
                ev = event_of(usbspi_pkg::EV_SPI_DONE);
                if (flash_phase == S_POLL_STATUS) begin
                    ev.status[0] = ($urandom_range(99) < 40);
                    status_polls++;
                end
            end
            issue_event(ev);
            steps++;
        end
        if (flash_phase != S_IDLE && flash_phase != S_DISABLED) begin
            issue_event(event_of($urandom_range(1) ? usbspi_pkg::EV_ENABLE
                                                   : usbspi_pkg::EV_DISABLE));
        end
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 3)) issue_event(event_of(OPCODE_W'($urandom())));
        end
    endtask

    task automatic test_back_to_back(input int n);
        int target;
        target        = events_sent + n;
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        while (events_sent < target) begin
            run_transaction();
        end
        wait_for_results();
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    task automatic test_random_traffic(input int n);
        int target;
        target = events_sent + n;
        while (events_sent < target) begin
            run_transaction();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_disabled_events();
        test_idle_events();
        test_flash_read_sequence();
        test_mid_flight_restart();
        wait_for_results();
        test_back_to_back(100);
        test_random_traffic(400);
        wait_for_results();
        if (expected_results.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        $display("Sent %0d events over %0d host packets with %0d status reads;",
                 events_sent, transactions, status_polls);
        $display("checked %0d results in %0d cycles, %0d mismatches.",
                 results_checked, cycle_count, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
